/* src/shelf_partition_min_height_core_defines.svh */
// Assertion macros for the shelf partition core.
// No dependencies; define ASSERT_OFF to drop every check.
`ifndef SHELF_PARTITION_MIN_HEIGHT_CORE_DEFINES_SVH
`define SHELF_PARTITION_MIN_HEIGHT_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define SPMH_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SPMH_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    `SPMH_ASSERT(lbl, clk, rstn, !(expr), msg)
`else
`define SPMH_ASSERT(lbl, clk, rstn, prop, msg)
`define SPMH_ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

/* src/spmh_pkg.sv */
// Shared types, constants and helpers for the shelf partition core.
// No dependencies; used by spmh_cell and shelf_partition_min_height_core.
package spmh_pkg;

    localparam int unsigned TW = 10;   // thickness, height and width fields
    localparam int unsigned SW = 11;   // stored group thickness
    localparam int unsigned BW = 32;   // totals

    localparam logic [BW-1:0] SAT32       = '1;
    localparam logic [TW-1:0] WIDTH_RESET = 10'd1023;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic          valid;
        logic [SW-1:0] sum;
        logic [TW-1:0] maxh;
        logic [BW-1:0] prior;
    } t_cell;

    typedef struct packed {
        logic          load;
        logic          shift;
        logic          clear;
        logic [TW-1:0] thickness;
        logic [TW-1:0] height;
        logic [TW-1:0] width;
    } t_cell_ctl;

    function automatic logic [BW-1:0] sat_add(input logic [BW-1:0] a, input logic [TW-1:0] b);
        logic [BW:0] s;
        s = {1'b0, a} + (BW+1)'(b);
        return s[BW] ? SAT32 : s[BW-1:0];
    endfunction

endpackage

/* src/shelf_partition_min_height_core.sv */
// Top level of the shelf partition core: config register, cell chain, control.
// Depends on spmh_pkg, spmh_cell and shelf_partition_min_height_core_defines.svh.
//
// Each book beat returns one beat with the least total shelf height so far.
// On the accept cycle every cell of the WINDOW-long chain updates its group
// at once; the candidates then shift one cell a cycle toward the chain end,
// where one comparator folds them into the minimum. The result is registered
// into the output register once the scan is done, and the core takes a new book
// only after that; a finished scan waits in ST_DONE while the result before it
// is not yet taken. The next book can be taken while a result waits.
`include "shelf_partition_min_height_core_defines.svh"

module shelf_partition_min_height_core #(
    parameter int unsigned WINDOW = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [spmh_pkg::TW-1:0]      i_cfg_wr_data,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [23:0]                  s_axis_tdata,  // book_thickness, book_height, pad
    input  logic                         s_axis_tuser,  // first_book
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [spmh_pkg::BW-1:0]      m_axis_tdata,  // best_total_height
    output logic                         m_axis_tuser   // window_limited
);
    import spmh_pkg::*;

    localparam int unsigned CW = (WINDOW > 2) ? $clog2(WINDOW) : 1;
    localparam logic [CW-1:0] CNT_LAST = CW'(WINDOW - 1);

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt;
    logic [TW-1:0] r_width;
    logic [BW-1:0] r_last_best;
    logic [BW-1:0] r_best;
    logic          r_wl;
    logic          r_out_valid;
    logic [BW-1:0] r_out_best;
    logic          r_out_wl;

    logic          accept;
    logic          out_free;
    logic          done_load;
    logic          scanning;
    logic [TW-1:0] bk_thick;
    logic [TW-1:0] bk_height;
    logic          bk_first;
    logic [SW:0]   wl_sum;
    logic          wl_hit;

    t_cell_ctl     cell_ctl;
    t_cell         head_in;
    t_cell         w_cell [WINDOW];
    logic [BW-1:0] w_cand [WINDOW];

    assign bk_thick  = s_axis_tdata[TW-1:0];
    assign bk_height = s_axis_tdata[2*TW-1:TW];
    assign bk_first  = s_axis_tuser;
    assign out_free  = ~r_out_valid | m_axis_tready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (s_axis_tvalid) n_state = ST_SCAN;
            ST_SCAN: if (r_cnt == CNT_LAST) n_state = ST_DONE;
            ST_DONE: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_axis_tready = 1'b0;
        scanning      = 1'b0;
        done_load     = 1'b0;
        unique case (r_state)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_SCAN: scanning      = 1'b1;
            ST_DONE: done_load     = out_free;
            default: s_axis_tready = 1'b0;
        endcase
    end

    assign accept = s_axis_tvalid & s_axis_tready;

    always_comb begin
        cell_ctl = '{load: accept, shift: scanning, clear: bk_first,
                     thickness: bk_thick, height: bk_height, width: r_width};
        head_in  = '{valid: 1'b1, sum: '0, maxh: '0,
                     prior: bk_first ? '0 : r_last_best};
        wl_sum   = {1'b0, w_cell[WINDOW-1].sum} + (SW+1)'(bk_thick);
        wl_hit   = w_cell[WINDOW-1].valid & ~bk_first & (wl_sum <= (SW+1)'(r_width));
    end

    for (genvar k = 0; k < WINDOW; k++) begin : g_cell
        if (k == 0) begin : g_head
            spmh_cell #(.HEAD(1'b1)) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (cell_ctl),
                .i_prev      (head_in),
                .i_prev_cand (SAT32),
                .o_cell      (w_cell[k]),
                .o_cand      (w_cand[k])
            );
        end else begin : g_body
            spmh_cell #(.HEAD(1'b0)) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (cell_ctl),
                .i_prev      (w_cell[k-1]),
                .i_prev_cand (w_cand[k-1]),
                .o_cell      (w_cell[k]),
                .o_cand      (w_cand[k])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_width     <= WIDTH_RESET;
            r_last_best <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_width <= i_cfg_wr_data;
            end
            if (accept) begin
                r_cnt <= '0;
            end else if (scanning) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (done_load) begin
                r_last_best <= r_best;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_best <= SAT32;
            r_wl   <= wl_hit;
        end else if (scanning && (w_cand[WINDOW-1] < r_best)) begin
            r_best <= w_cand[WINDOW-1];
        end
        if (done_load) begin
            r_out_best <= r_best;
            r_out_wl   <= r_wl;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_best;
    assign m_axis_tuser  = r_out_wl;

    `SPMH_ASSERT(a_best_monotone, i_clk, i_rst_n,
        (r_state == ST_SCAN && $past(r_state) == ST_SCAN) |-> (r_best <= $past(r_best)),
        "running minimum grew during scan")
    `SPMH_ASSERT(a_out_matches_last, i_clk, i_rst_n,
        done_load |=> (m_axis_tvalid && m_axis_tdata == r_last_best),
        "result beat differs from stored best")
    `SPMH_ASSERT_NEVER(a_first_no_wl, i_clk, i_rst_n,
        accept && bk_first && wl_hit,
        "window flag raised on a first book")

endmodule

/* src/spmh_cell.sv */
// One cell of the candidate chain: the last-shelf group starting at a fixed
// distance back from the current book. Depends on spmh_pkg.
module spmh_cell #(
    parameter bit HEAD = 1'b0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  spmh_pkg::t_cell_ctl     i_ctl,
    input  spmh_pkg::t_cell         i_prev,
    input  logic [spmh_pkg::BW-1:0] i_prev_cand,
    output spmh_pkg::t_cell         o_cell,
    output logic [spmh_pkg::BW-1:0] o_cand
);
    import spmh_pkg::*;

    logic          r_valid;
    logic [SW-1:0] r_sum;
    logic [TW-1:0] r_maxh;
    logic [BW-1:0] r_prior;
    logic [BW-1:0] r_cand;

    logic          v_in;
    logic [SW:0]   sum_full;
    logic          fits;
    logic [TW-1:0] maxh;
    logic [BW-1:0] n_cand;

    always_comb begin
        v_in     = i_prev.valid & (HEAD | ~i_ctl.clear);
        sum_full = {1'b0, i_prev.sum} + (SW+1)'(i_ctl.thickness);
        fits     = sum_full <= (SW+1)'(i_ctl.width);
        maxh     = (i_ctl.height > i_prev.maxh) ? i_ctl.height : i_prev.maxh;
        n_cand   = (v_in & (HEAD | fits)) ? sat_add(i_prev.prior, maxh) : SAT32;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.load) begin
            r_valid <= v_in & fits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_sum   <= sum_full[SW-1:0];
            r_maxh  <= maxh;
            r_prior <= i_prev.prior;
            r_cand  <= n_cand;
        end else if (i_ctl.shift) begin
            r_cand  <= i_prev_cand;
        end
    end

    assign o_cell = '{valid: r_valid, sum: r_sum, maxh: r_maxh, prior: r_prior};
    assign o_cand = r_cand;

endmodule

/* test/shelf_partition_min_height_core_test.sv */
// Self-checking bench for shelf_partition_min_height_core: directed rows, then random book runs.
// Predicts the running least shelf height per book and compares every result beat.
// Depends on spmh_pkg and the core RTL only.
module shelf_partition_min_height_core_test;
    import spmh_pkg::*;

    localparam int WIN          = 64;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 3000;

    typedef enum logic {ROW_BOOK, ROW_WIDTH} t_row_kind;

    typedef struct packed {
        t_row_kind     kind;
        logic [TW-1:0] val;     // thickness, or new width for ROW_WIDTH
        logic [TW-1:0] height;
        logic          first;
        logic          typed;
        logic [BW-1:0] best;
        logic          lim;
    } t_shelf_row;

    typedef struct packed {
        logic [BW-1:0] best;
        logic          lim;
    } t_shelf_total;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_wr_en;
    logic [TW-1:0] i_cfg_wr_data;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [23:0]   s_axis_tdata;   // book_thickness, book_height, pad
    logic          s_axis_tuser;   // first_book
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [BW-1:0] m_axis_tdata;   // best_total_height
    logic          m_axis_tuser;   // window_limited

    // shelf model state
    logic [SW-1:0] grp_sum   [WIN] = '{default: '0};
    logic [TW-1:0] grp_maxh  [WIN] = '{default: '0};
    logic [BW-1:0] grp_prior [WIN] = '{default: '0};
    logic          grp_live  [WIN] = '{default: 1'b0};
    logic [BW-1:0] prev_best = '0;
    logic [TW-1:0] shelf_w;

    t_shelf_total  totals_due [$];
    int            bad_count = 0;
    int            idle_run = 0;
    logic          calm;
    logic          hold_req;
    logic          row_typed;
    logic [BW-1:0] row_best;
    logic          row_lim;

    t_shelf_row plan_rows [23] = '{
        '{ROW_BOOK,  10'd5,    10'd7,    1'b0, 1'b1, 32'd7,    1'b0},
        '{ROW_BOOK,  10'd1023, 10'd1023, 1'b0, 1'b1, 32'd1030, 1'b0},
        '{ROW_BOOK,  10'd1,    10'd1,    1'b1, 1'b1, 32'd1,    1'b0},
        '{ROW_BOOK,  10'd1,    10'd1023, 1'b0, 1'b0, 32'd0,    1'b0},
        '{ROW_BOOK,  10'd0,    10'd0,    1'b0, 1'b0, 32'd0,    1'b0},
        '{ROW_BOOK,  10'd1023, 10'd1,    1'b0, 1'b0, 32'd0,    1'b0},
        '{ROW_WIDTH, 10'd1,    10'd0,    1'b0, 1'b0, 32'd0,    1'b0},
        '{ROW_BOOK,  10'd1023, 10'd5,    1'b1, 1'b1, 32'd5,    1'b0},
        '{ROW_BOOK,  10'd1,    10'd3,    1'b0, 1'b1, 32'd8,    1'b0},
        '{ROW_BOOK,  10'd1,    10'd9,    1'b0, 1'b0, 32'd0,    1'b0},
        '{ROW_WIDTH, 10'd0,    10'd0,    1'b0, 1'b0, 32'd0,    1'b0},
        '{ROW_BOOK,  10'd1,    10'd4,    1'b1, 1'b1, 32'd4,    1'b0},
        '{ROW_BOOK,  10'd0,    10'd6,    1'b0, 1'b0, 32'd0,    1'b0},
        '{ROW_BOOK,  10'd0,    10'd2,    1'b0, 1'b0, 32'd0,    1'b0},
        '{ROW_WIDTH, 10'd1023, 10'd0,    1'b0, 1'b0, 32'd0,    1'b0},
        '{ROW_BOOK,  10'd1023, 10'd1023, 1'b1, 1'b1, 32'd1023, 1'b0},
        '{ROW_BOOK,  10'd1,    10'd1,    1'b1, 1'b1, 32'd1,    1'b0},
        '{ROW_BOOK,  10'd511,  10'd600,  1'b0, 1'b0, 32'd0,    1'b0},
        '{ROW_BOOK,  10'd511,  10'd2,    1'b0, 1'b0, 32'd0,    1'b0},
        '{ROW_BOOK,  10'd1,    10'd1023, 1'b0, 1'b0, 32'd0,    1'b0},
        '{ROW_WIDTH, 10'd512,  10'd0,    1'b0, 1'b0, 32'd0,    1'b0},
        '{ROW_BOOK,  10'd512,  10'd100,  1'b1, 1'b1, 32'd100,  1'b0},
        '{ROW_BOOK,  10'd513,  10'd50,   1'b0, 1'b0, 32'd0,    1'b0}
    };

    shelf_partition_min_height_core #(
        .WINDOW (WIN)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // One book onto the shelves: shift the candidate groups, extend each, take the least total.
    function automatic void stack_book(input logic [TW-1:0] t, input logic [TW-1:0] h,
                                       input logic fb, output logic [BW-1:0] best,
                                       output logic lim);
        logic [SW:0] sum;
        logic [BW:0] cand;
        best = SAT32;
        if (fb) begin
            for (int k = 0; k < WIN; k++) grp_live[k] = 1'b0;
            prev_best = '0;
        end
        lim = grp_live[WIN-1] && (({1'b0, grp_sum[WIN-1]} + t) <= shelf_w);
        for (int k = WIN - 1; k > 0; k--) begin
            grp_sum[k]   = grp_sum[k-1];
            grp_maxh[k]  = grp_maxh[k-1];
            grp_prior[k] = grp_prior[k-1];
            grp_live[k]  = grp_live[k-1];
        end
        grp_sum[0]   = '0;
        grp_maxh[0]  = '0;
        grp_prior[0] = prev_best;
        grp_live[0]  = 1'b1;
        for (int k = 0; k < WIN; k++) begin
            if (grp_live[k]) begin
                sum = {1'b0, grp_sum[k]} + t;
                grp_sum[k] = sum[SW-1:0];
                if (h > grp_maxh[k]) grp_maxh[k] = h;
                if (k > 0 && sum > shelf_w) begin
                    grp_live[k] = 1'b0;
                end else begin
                    cand = {1'b0, grp_prior[k]} + grp_maxh[k];
                    if (cand[BW]) cand[BW-1:0] = SAT32;
                    if (cand[BW-1:0] < best) best = cand[BW-1:0];
                end
            end
        end
        // a lone book wider than the shelf takes no partners later
        if (grp_sum[0] > shelf_w) grp_live[0] = 1'b0;
        prev_best = best;
    endfunction

    function automatic void flag_mismatch(input string what, input t_shelf_total want);
        bad_count++;
        if (bad_count <= 10)
            $display("%s: expected best=%0d lim=%0b, got best=%0d lim=%0b", what,
                     want.best, want.lim, m_axis_tdata, m_axis_tuser);
    endfunction

    always @(posedge i_clk) begin : beat_monitor
        t_shelf_total  due;
        logic [BW-1:0] best;
        logic          lim;
        logic          moved;
        moved = 1'b0;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            moved = 1'b1;
            stack_book(s_axis_tdata[TW-1:0], s_axis_tdata[2*TW-1:TW], s_axis_tuser, best, lim);
            if (row_typed) begin
                best = row_best;
                lim  = row_lim;
            end
            totals_due.push_back('{best: best, lim: lim});
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            moved = 1'b1;
            if (totals_due.size() == 0) begin
                flag_mismatch("unexpected result beat", '0);
            end else begin
                due = totals_due.pop_front();
                if (m_axis_tdata !== due.best || m_axis_tuser !== due.lim)
                    flag_mismatch("result mismatch", due);
            end
        end
        idle_run = moved ? 0 : idle_run + 1;
    end

    initial begin : watchdog
        while (idle_run < STALL_LIMIT) @(posedge i_clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : results_sink
        int stall;
        bit held;
        held = 1'b0;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_req && !held) begin
                @(negedge i_clk);
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                held = 1'b1;
            end
            stall = calm ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                @(negedge i_clk);
                m_axis_tready = 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    task automatic send_book(input logic [TW-1:0] t, input logic [TW-1:0] h, input logic fb,
                             input logic typed, input logic [BW-1:0] best, input logic lim);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {4'b0, h, t};
        s_axis_tuser  = fb;
        row_typed     = typed;
        row_best      = best;
        row_lim       = lim;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // drain, then write the width register while the core is idle
    task automatic set_shelf_width(input logic [TW-1:0] w);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (totals_due.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = w;
        shelf_w       = w;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
    endtask

    initial begin : stimulus
        logic [TW-1:0] plan_width [6];
        logic [TW-1:0] t;
        logic [TW-1:0] h;
        logic          fb;
        int            seq_left;
        int            mode;
        int            n;

        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        calm          = 1'b0;
        hold_req      = 1'b0;
        row_typed     = 1'b0;
        row_best      = '0;
        row_lim       = 1'b0;
        shelf_w       = WIDTH_RESET;

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (plan_rows[r]) begin
            if (plan_rows[r].kind == ROW_WIDTH)
                set_shelf_width(plan_rows[r].val);
            else
                send_book(plan_rows[r].val, plan_rows[r].height, plan_rows[r].first,
                          plan_rows[r].typed, plan_rows[r].best, plan_rows[r].lim);
        end

        plan_width = '{10'd1023, 10'd1, 10'd512, 10'd0, 10'd200, 10'd1023};
        plan_width[3] = TW'($urandom_range(1, 1023));
        seq_left = 0;
        mode     = 0;
        for (int p = 0; p < 6; p++) begin
            set_shelf_width(plan_width[p]);
            n = 0;
            while (n < 30 || seq_left > 0) begin
                if (seq_left == 0) begin
                    seq_left = ($urandom_range(0, 2) == 0) ? $urandom_range(66, 100)
                                                           : $urandom_range(1, 30);
                    mode = $urandom_range(0, 2);
                    calm = ($urandom_range(0, 3) == 0);
                    fb   = 1'b1;
                end else begin
                    fb = (mode != 0) && ($urandom_range(0, 39) == 0);
                end
                seq_left--;
                unique case (mode)
                    0:       t = TW'($urandom_range(1, 8));
                    1:       t = TW'($urandom_range(1, shelf_w / 3 + 1));
                    default: t = TW'($urandom_range(1, 1023));
                endcase
                h = ($urandom_range(0, 4) == 0) ? TW'($urandom_range(1, 15))
                                                : TW'($urandom_range(1, 1023));
                if (p == 1 && n == 8) hold_req = 1'b1;
                send_book(t, h, fb, 1'b0, '0, 1'b0);
                n++;
            end
        end

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (totals_due.size() != 0) @(posedge i_clk);
        repeat (WIN + 8) @(posedge i_clk);
        if (bad_count == 0 && totals_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
